// ===== design/rnm_pkg.sv =====
// shared types, widths and codes of the rotated nearest node matcher
`default_nettype none
package rnm_pkg;
   localparam int NODE_ID_BITS  = 20;
   localparam int COORD_BITS    = 32;
   localparam int SLOT_BITS     = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 48;
   localparam int TABLE_DEPTH_DEF = 256;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_MATCH = 2'd1,
      MODE_READ  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_MATCH   = 2'd1,
      STAT_FULL       = 2'd2,
      STAT_NOT_LOADED = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ROT_COS = 3'd0,
      CSR_ROT_SIN = 3'd1,
      CSR_AXIS    = 3'd2,
      CSR_ABS_TOL = 3'd3,
      CSR_REL_TOL = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LOAD_MUL,
      ST_LOAD_SUM,
      ST_LOAD_WR,
      ST_TOL_SQ,
      ST_TOL_SUM,
      ST_TOL_MUL,
      ST_TOL_MID,
      ST_TOL_LOW,
      ST_TOL_FIN,
      ST_SCAN,
      ST_DECIDE,
      ST_READ,
      ST_RESP
   } state_type;
endpackage
`default_nettype wire

// ===== design/rnm_req_if.sv =====
// request channel: one node word per handshake
`default_nettype none
interface rnm_req_if;
   import rnm_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   mode;
   logic [NODE_ID_BITS-1:0]      node_id;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;
   logic [SLOT_BITS-1:0]         slot_index;

   modport source (output valid, mode, node_id, coord_x, coord_y, coord_z, slot_index,
                   input ready);
   modport sink (input valid, mode, node_id, coord_x, coord_y, coord_z, slot_index,
                 output ready);
endinterface
`default_nettype wire

// ===== design/rnm_rsp_if.sv =====
// response channel: one result word per handshake
`default_nettype none
interface rnm_rsp_if;
   import rnm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic [NODE_ID_BITS-1:0] left_id;
   logic [NODE_ID_BITS-1:0] right_id;
   logic [SLOT_BITS-1:0]    slot_found;
   logic                    slot_used;

   modport source (output valid, status, left_id, right_id, slot_found, slot_used,
                   input ready);
   modport sink (input valid, status, left_id, right_id, slot_found, slot_used,
                 output ready);
endinterface
`default_nettype wire

// ===== design/rotated_nearest_node_matcher.sv =====
// rotated nearest node matcher: node table in block memory with a pipelined distance scan
`default_nettype none
// One word at a time. After acceptance, a load passes rotate, round and write, a read slot
// passes the table read and a clear goes straight to its result, as do a load into a full
// table and a read of an unloaded slot. A match runs the tolerance math (square, sum,
// multiply, middle sum, low sum, final), then one table entry per cycle through the single
// read port of the node memory, then waits while the distance pipeline drains, then the
// decision. A new request is taken in the cycle after the previous one has placed its
// result in the output register, which waits there as long as the receiver holds ready
// low. The table needs no clearing pass.
module rotated_nearest_node_matcher #(
   parameter int TABLE_DEPTH = rnm_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rnm_req_if.sink                               req_bus,
   rnm_rsp_if.source                             rsp_bus,
   input  wire logic                             csr_we,
   input  wire logic [rnm_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [rnm_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import rnm_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = CW + SLOT_BITS;
   localparam logic signed [65:0] C_MAX = (66'sd1 <<< (COORD_BITS - 1)) - 66'sd1;
   localparam logic signed [65:0] C_MIN = -(66'sd1 <<< (COORD_BITS - 1));
   localparam logic signed [65:0] RND   = 66'sd1 <<< 29;

   typedef struct packed {
      logic [NODE_ID_BITS-1:0]      id;
      logic signed [COORD_BITS-1:0] a;
      logic signed [COORD_BITS-1:0] b;
      logic signed [COORD_BITS-1:0] ax;
   } entry_type;

   function automatic logic [31:0] abs_diff(input logic signed [COORD_BITS-1:0] p,
                                            input logic signed [COORD_BITS-1:0] q);
      logic signed [32:0] d;
      d = 33'(p) - 33'(q);
      abs_diff = d[32] ? 32'(-d) : d[31:0];
   endfunction

   function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [65:0] s);
      logic signed [65:0] t;
      t = (s + RND) >>> 30;
      if (t > C_MAX) round_sat = C_MAX[COORD_BITS-1:0];
      else if (t < C_MIN) round_sat = C_MIN[COORD_BITS-1:0];
      else round_sat = t[COORD_BITS-1:0];
   endfunction

   function automatic logic [SLOT_BITS-1:0] low_slot(input logic [XW-1:0] v);
      low_slot = v[SLOT_BITS-1:0];
   endfunction

   // configuration
   logic signed [31:0] cos_ff, sin_ff;
   logic [1:0]         axis_ff;
   logic [31:0]        abs_tol_ff;
   logic [47:0]        rel_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff     <= 32'sh4000_0000;
         sin_ff     <= '0;
         axis_ff    <= AXIS_Z;
         abs_tol_ff <= 32'd1;
         rel_tol_ff <= 48'd2814750;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ROT_COS: cos_ff     <= csr_wdata[31:0];
            CSR_ROT_SIN: sin_ff     <= csr_wdata[31:0];
            CSR_AXIS:    axis_ff    <= csr_wdata[1:0];
            CSR_ABS_TOL: abs_tol_ff <= csr_wdata[31:0];
            CSR_REL_TOL: rel_tol_ff <= csr_wdata[47:0];
            default: ;
         endcase
      end
   end

   // control state
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          have_ff, have_in;
   logic          p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff, p1_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // captured word, plane mapped
   mode_type                     mode_ff;
   logic [NODE_ID_BITS-1:0]      id_ff;
   logic signed [COORD_BITS-1:0] pl1_ff, pl2_ff, pax_ff;
   logic [SLOT_BITS-1:0]         slot_ff;

   // result fields
   status_type              res_status_ff, res_status_in;
   logic [NODE_ID_BITS-1:0] res_left_ff, res_left_in, res_right_ff, res_right_in;
   logic [SLOT_BITS-1:0]    res_found_ff, res_found_in;
   logic                    res_used_ff, res_used_in;

   // output register
   status_type              out_status_ff;
   logic [NODE_ID_BITS-1:0] out_left_ff, out_right_ff;
   logic [SLOT_BITS-1:0]    out_found_ff;
   logic                    out_used_ff;
   logic                    out_load;

   // memories
   entry_type ent_mem [TABLE_DEPTH];
   logic      used_mem [TABLE_DEPTH];
   entry_type ent_q;
   logic      used_q;
   logic [AW-1:0] rd_addr, ent_waddr, used_waddr;
   logic          ent_we, used_we, used_wdata;
   entry_type     ent_wdata;

   // datapath registers
   logic signed [63:0] prod_cp_ff, prod_sp_ff, prod_sp1_ff, prod_cp2_ff;
   logic signed [COORD_BITS-1:0] rot_a_ff, rot_b_ff;
   logic [63:0]  sq1_ff, sq2_ff, ssum_ff;
   logic [63:0]  pll_ff, plh_ff;
   logic [47:0]  phl_ff, phh_ff;
   logic [64:0]  pmid_ff;
   logic [96:0]  plow_ff;
   logic [63:0]  tol_ff;
   logic [CW-1:0] p1_idx_ff, p2_idx_ff, p3_idx_ff, p4_idx_ff;
   logic [NODE_ID_BITS-1:0] p2_id_ff, p3_id_ff, p4_id_ff;
   logic [31:0]  da_ff, db_ff, dx_ff;
   logic [63:0]  qa_ff, qb_ff, qx_ff, dist_ff;
   logic [63:0]  best_d_ff;
   logic [CW-1:0] best_idx_ff;
   logic [NODE_ID_BITS-1:0] best_id_ff;

   logic          issue, accept, hit;
   logic [XW-1:0] slot_ext;
   logic [111:0]  tol_full;
   logic [65:0]   dist_sum;

   assign accept   = req_bus.valid && req_bus.ready;
   assign slot_ext = XW'(slot_ff);
   assign issue    = (state_ff == ST_SCAN) && (scan_ff < count_ff);
   assign hit      = have_ff && (best_d_ff <= tol_ff);
   assign tol_full = 112'(plow_ff) + {phh_ff, 64'd0};
   assign dist_sum = 66'(qa_ff) + 66'(qb_ff) + 66'(qx_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      have_in       = have_ff;
      p1_vld_in     = 1'b0;
      res_status_in = res_status_ff;
      res_left_in   = res_left_ff;
      res_right_in  = res_right_ff;
      res_found_in  = res_found_ff;
      res_used_in   = res_used_ff;
      out_load      = 1'b0;
      rd_addr       = scan_ff[AW-1:0];
      ent_we        = 1'b0;
      ent_waddr     = count_ff[AW-1:0];
      ent_wdata     = '{id: id_ff, a: rot_a_ff, b: rot_b_ff, ax: pax_ff};
      used_we       = 1'b0;
      used_waddr    = count_ff[AW-1:0];
      used_wdata    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            res_status_in = STAT_OK;
            res_left_in   = '0;
            res_right_in  = '0;
            res_found_in  = '0;
            res_used_in   = 1'b0;
            case (mode_ff)
               MODE_LOAD: begin
                  if (count_ff >= CW'(TABLE_DEPTH)) begin
                     res_status_in = STAT_FULL;
                     state_in      = ST_RESP;
                  end else begin
                     state_in = ST_LOAD_MUL;
                  end
               end
               MODE_MATCH: begin
                  have_in  = 1'b0;
                  scan_in  = '0;
                  state_in = ST_TOL_SQ;
               end
               MODE_READ: begin
                  rd_addr = slot_ext[AW-1:0];
                  if (slot_ext < XW'(count_ff)) begin
                     state_in = ST_READ;
                  end else begin
                     res_status_in = STAT_NOT_LOADED;
                     state_in      = ST_RESP;
                  end
               end
               default: begin
                  // used flags need no wipe: every load rewrites its own flag
                  count_in = '0;
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_LOAD_MUL: state_in = ST_LOAD_SUM;
         ST_LOAD_SUM: state_in = ST_LOAD_WR;
         ST_LOAD_WR: begin
            ent_we       = 1'b1;
            used_we      = 1'b1;
            count_in     = CW'(count_ff + 1'b1);
            res_right_in = id_ff;
            res_found_in = low_slot(XW'(count_ff));
            state_in     = ST_RESP;
         end
         ST_TOL_SQ:  state_in = ST_TOL_SUM;
         ST_TOL_SUM: state_in = ST_TOL_MUL;
         ST_TOL_MUL: state_in = ST_TOL_MID;
         ST_TOL_MID: state_in = ST_TOL_LOW;
         ST_TOL_LOW: state_in = ST_TOL_FIN;
         ST_TOL_FIN: state_in = ST_SCAN;
         ST_SCAN: begin
            if (issue) begin
               p1_vld_in = 1'b1;
               scan_in   = CW'(scan_ff + 1'b1);
            end else if (!p1_vld_ff && !p2_vld_ff && !p3_vld_ff && !p4_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_left_in = id_ff;
            used_waddr  = best_idx_ff[AW-1:0];
            used_wdata  = 1'b1;
            if (hit) begin
               used_we      = 1'b1;
               res_right_in = best_id_ff;
               res_found_in = low_slot(XW'(best_idx_ff));
            end else begin
               res_status_in = STAT_NO_MATCH;
            end
            state_in = ST_RESP;
         end
         ST_READ: begin
            res_right_in = ent_q.id;
            res_found_in = slot_ff;
            res_used_in  = used_q;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         have_ff      <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
         p4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p1_vld_ff && !used_q;
         p3_vld_ff    <= p2_vld_ff;
         p4_vld_ff    <= p3_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (p4_vld_ff && (!have_ff || dist_ff < best_d_ff)) have_ff <= 1'b1;
         else have_ff <= have_in;
      end
   end

   // node memory, one write and one registered read port each
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
      ent_q <= ent_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (used_we) used_mem[used_waddr] <= used_wdata;
      used_q <= used_mem[rd_addr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_left_ff   <= res_left_in;
      res_right_ff  <= res_right_in;
      res_found_ff  <= res_found_in;
      res_used_ff   <= res_used_in;
      if (accept) begin
         mode_ff <= mode_type'(req_bus.mode);
         id_ff   <= req_bus.node_id;
         slot_ff <= req_bus.slot_index;
         case (axis_ff)
            AXIS_X: begin
               pl1_ff <= req_bus.coord_y;
               pl2_ff <= req_bus.coord_z;
               pax_ff <= req_bus.coord_x;
            end
            AXIS_Y: begin
               pl1_ff <= req_bus.coord_x;
               pl2_ff <= req_bus.coord_z;
               pax_ff <= req_bus.coord_y;
            end
            default: begin
               pl1_ff <= req_bus.coord_x;
               pl2_ff <= req_bus.coord_y;
               pax_ff <= req_bus.coord_z;
            end
         endcase
      end
      if (out_load) begin
         out_status_ff <= res_status_ff;
         out_left_ff   <= res_left_ff;
         out_right_ff  <= res_right_ff;
         out_found_ff  <= res_found_ff;
         out_used_ff   <= res_used_ff;
      end
   end

   // rotation: four products, then round to Q16.16 and saturate
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD_MUL) begin
         prod_cp_ff  <= 64'(cos_ff) * 64'(pl1_ff);
         prod_sp_ff  <= 64'(sin_ff) * 64'(pl2_ff);
         prod_sp1_ff <= 64'(sin_ff) * 64'(pl1_ff);
         prod_cp2_ff <= 64'(cos_ff) * 64'(pl2_ff);
      end
      if (state_ff == ST_LOAD_SUM) begin
         rot_a_ff <= round_sat(66'(prod_cp_ff) - 66'(prod_sp_ff));
         rot_b_ff <= round_sat(66'(prod_sp1_ff) + 66'(prod_cp2_ff));
      end
   end

   // tolerance: larger of abs_tol and (rel * (l1^2 + l2^2)) >> 48, from 32- and 16-bit partial products
   always_ff @(posedge clock) begin
      if (state_ff == ST_TOL_SQ) begin
         sq1_ff <= 64'(abs_diff(pl1_ff, '0)) * 64'(abs_diff(pl1_ff, '0));
         sq2_ff <= 64'(abs_diff(pl2_ff, '0)) * 64'(abs_diff(pl2_ff, '0));
      end
      if (state_ff == ST_TOL_SUM) ssum_ff <= sq1_ff + sq2_ff;
      if (state_ff == ST_TOL_MUL) begin
         pll_ff <= 64'(rel_tol_ff[31:0]) * 64'(ssum_ff[31:0]);
         plh_ff <= 64'(rel_tol_ff[31:0]) * 64'(ssum_ff[63:32]);
         phl_ff <= 48'(rel_tol_ff[47:32]) * 48'(ssum_ff[31:0]);
         phh_ff <= 48'(rel_tol_ff[47:32]) * 48'(ssum_ff[63:32]);
      end
      if (state_ff == ST_TOL_MID) pmid_ff <= 65'(plh_ff) + 65'(phl_ff);
      if (state_ff == ST_TOL_LOW) plow_ff <= 97'(pll_ff) + {pmid_ff, 32'd0};
      if (state_ff == ST_TOL_FIN) begin
         if (tol_full[111:48] > 64'(abs_tol_ff)) tol_ff <= tol_full[111:48];
         else tol_ff <= 64'(abs_tol_ff);
      end
   end

   // distance pipeline: difference, square, saturating sum, best compare
   always_ff @(posedge clock) begin
      p1_idx_ff <= scan_ff;
      da_ff     <= abs_diff(pl1_ff, ent_q.a);
      db_ff     <= abs_diff(pl2_ff, ent_q.b);
      dx_ff     <= abs_diff(pax_ff, ent_q.ax);
      p2_idx_ff <= p1_idx_ff;
      p2_id_ff  <= ent_q.id;
      qa_ff     <= 64'(da_ff) * 64'(da_ff);
      qb_ff     <= 64'(db_ff) * 64'(db_ff);
      qx_ff     <= 64'(dx_ff) * 64'(dx_ff);
      p3_idx_ff <= p2_idx_ff;
      p3_id_ff  <= p2_id_ff;
      dist_ff   <= (dist_sum[65:64] != 2'b00) ? '1 : dist_sum[63:0];
      p4_idx_ff <= p3_idx_ff;
      p4_id_ff  <= p3_id_ff;
      // strict less keeps the lowest slot on a tie
      if (p4_vld_ff && (!have_ff || dist_ff < best_d_ff)) begin
         best_d_ff   <= dist_ff;
         best_idx_ff <= p4_idx_ff;
         best_id_ff  <= p4_id_ff;
      end
   end

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = out_status_ff;
   assign rsp_bus.left_id    = out_left_ff;
   assign rsp_bus.right_id   = out_right_ff;
   assign rsp_bus.slot_found = out_found_ff;
   assign rsp_bus.slot_used  = out_used_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(p1_vld_ff || p2_vld_ff || p3_vld_ff || p4_vld_ff))
      else $error("scan pipeline busy outside a match");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff <= count_ff))
      else $error("scan ran past loaded entries");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISPATCH && mode_ff == MODE_CLEAR) |=> (count_ff == '0))
      else $error("clear left entries in table");

   a_hit_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && used_we) |-> have_ff)
      else $error("match marked without a candidate");
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench of the rotated nearest node matcher with its own prediction of each word
`default_nettype none
module testbench;
   import rnm_pkg::*;

   localparam int DEPTH      = 256;
   localparam int CYCLE_CAP  = 3000000;
   localparam int DRAIN_WAIT = 300;

   typedef struct {
      mode_type                mode;
      logic [NODE_ID_BITS-1:0] node_id;
      logic [31:0]             x, y, z;
      logic [SLOT_BITS-1:0]    slot;
   } node_word_type;

   typedef struct {
      status_type              status;
      logic [NODE_ID_BITS-1:0] left_id;
      logic [NODE_ID_BITS-1:0] right_id;
      logic [SLOT_BITS-1:0]    slot_found;
      logic                    slot_used;
   } match_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   rnm_req_if req_bus();
   rnm_rsp_if rsp_bus();

   rotated_nearest_node_matcher dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the node table and registers
   logic [NODE_ID_BITS-1:0] tbl_id    [DEPTH];
   longint                  tbl_a     [DEPTH];
   longint                  tbl_b     [DEPTH];
   longint                  tbl_axial [DEPTH];
   bit                      tbl_used  [DEPTH];
   int                      tbl_count;
   logic [31:0] cos_q = 32'h4000_0000;
   logic [31:0] sin_q = 32'h0;
   logic [1:0]  axis_q = 2'd2;
   logic [31:0] abs_tol_q = 32'd1;
   logic [47:0] rel_tol_q = 48'd2814750;

   node_word_type    pending_words[$];
   match_result_type expected_results[$];
   int  mismatches = 0;
   int  cycles = 0;
   int  send_idle_pct = 12;
   int  recv_idle_pct = 66;
   bit  req_taken = 1'b0;

   initial forever #2 clock = ~clock;

   function automatic logic [63:0] dist_sq(longint a, longint b);
      longint      d;
      logic [63:0] m;
      d = a - b;
      m = (d < 0) ? -d : d;
      return m * m;
   endfunction

   function automatic longint rotate_round(longint s);
      longint r;
      r = (s + (64'sd1 <<< 29)) >>> 30;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
   endfunction

   function automatic void split_axes(node_word_type w, output longint p1, p2, pax);
      longint sx, sy, sz;
      sx = longint'($signed(w.x));
      sy = longint'($signed(w.y));
      sz = longint'($signed(w.z));
      case (axis_q)
         AXIS_X: begin p1 = sy; p2 = sz; pax = sx; end
         AXIS_Y: begin p1 = sx; p2 = sz; pax = sy; end
         default: begin p1 = sx; p2 = sy; pax = sz; end
      endcase
   endfunction

   function automatic match_result_type predict_word(node_word_type w);
      match_result_type r;
      longint        p1, p2, pax, c, s;
      logic [64:0]   d;
      logic [63:0]   best_d, tol, rel;
      logic [111:0]  prod;
      bit            have;
      int            best;
      r = '{STAT_OK, '0, '0, '0, 1'b0};
      split_axes(w, p1, p2, pax);
      case (w.mode)
         MODE_LOAD: begin
            if (tbl_count >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               c = longint'($signed(cos_q));
               s = longint'($signed(sin_q));
               tbl_id[tbl_count]    = w.node_id;
               tbl_a[tbl_count]     = rotate_round(c * p1 - s * p2);
               tbl_b[tbl_count]     = rotate_round(s * p1 + c * p2);
               tbl_axial[tbl_count] = pax;
               tbl_used[tbl_count]  = 1'b0;
               r.right_id = w.node_id;
               r.slot_found = tbl_count[7:0];
               tbl_count++;
            end
         end
         MODE_MATCH: begin
            have = 1'b0;
            best = 0;
            best_d = '0;
            for (int j = 0; j < tbl_count; j++) begin
               if (!tbl_used[j]) begin
                  d = {1'b0, dist_sq(p1, tbl_a[j])} + dist_sq(p2, tbl_b[j]);
                  if (d[64]) d = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
                  d = d + dist_sq(pax, tbl_axial[j]);
                  if (d[64]) d = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
                  if (!have || d[63:0] < best_d) begin
                     have = 1'b1;
                     best_d = d[63:0];
                     best = j;
                  end
               end
            end
            prod = {64'b0, rel_tol_q} * {48'b0, dist_sq(p1, 0) + dist_sq(p2, 0)};
            rel = prod[111:48];
            tol = (rel > {32'b0, abs_tol_q}) ? rel : {32'b0, abs_tol_q};
            r.left_id = w.node_id;
            if (have && best_d <= tol) begin
               tbl_used[best] = 1'b1;
               r.right_id = tbl_id[best];
               r.slot_found = best[7:0];
            end else begin
               r.status = STAT_NO_MATCH;
            end
         end
         MODE_READ: begin
            if (int'(w.slot) < tbl_count) begin
               r.right_id = tbl_id[w.slot];
               r.slot_found = w.slot;
               r.slot_used = tbl_used[w.slot];
            end else begin
               r.status = STAT_NOT_LOADED;
            end
         end
         default: begin
            tbl_count = 0;
            foreach (tbl_used[j]) tbl_used[j] = 1'b0;
         end
      endcase
      return r;
   endfunction

   task automatic queue_word(mode_type mode, logic [NODE_ID_BITS-1:0] id,
                             logic [31:0] x, y, z, logic [SLOT_BITS-1:0] slot);
      node_word_type w;
      w = '{mode, id, x, y, z, slot};
      pending_words = {pending_words, w};
      expected_results = {expected_results, predict_word(w)};
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      endcase
   endfunction

   // left node placed on a stored entry, offset by a small noise
   task automatic queue_near_match(int j, int noise);
      logic [31:0] q1, q2, qa;
      q1 = 32'(tbl_a[j] + $urandom_range(0, noise));
      q2 = 32'(tbl_b[j] - $urandom_range(0, noise));
      qa = 32'(tbl_axial[j] + $urandom_range(0, noise));
      case (axis_q)
         AXIS_X: queue_word(MODE_MATCH, $urandom(), qa, q1, q2, $urandom());
         AXIS_Y: queue_word(MODE_MATCH, $urandom(), q1, qa, q2, $urandom());
         default: queue_word(MODE_MATCH, $urandom(), q1, q2, qa, $urandom());
      endcase
   endtask

   task automatic wait_idle();
      wait (pending_words.size() == 0 && !req_bus.valid && expected_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_ROT_COS: cos_q = value[31:0];
         CSR_ROT_SIN: sin_q = value[31:0];
         CSR_AXIS:    axis_q = value[1:0];
         CSR_ABS_TOL: abs_tol_q = value[31:0];
         default:     rel_tol_q = value[47:0];
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic random_round(int budget);
      int n, j, k;
      k = 0;
      while (k < budget) begin
         queue_word(MODE_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
         for (int i = 0; i < n; i++)
            queue_word(MODE_LOAD, $urandom(), rand_coord(), rand_coord(), rand_coord(),
                       $urandom());
         k += n + 1;
         for (int i = 0; i < n + 4; i++) begin
            j = $urandom_range(0, n - 1);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: queue_near_match(j, 0);
               4, 5:       queue_near_match(j, 1 << $urandom_range(0, 12));
               6:          queue_word(MODE_MATCH, $urandom(), rand_coord(), rand_coord(),
                                      rand_coord(), $urandom());
               7:          queue_word(MODE_READ, $urandom(), $urandom(), $urandom(),
                                      $urandom(), $urandom());
               8:          queue_word(MODE_READ, $urandom(), $urandom(), $urandom(),
                                      $urandom(), $urandom_range(0, n + 1));
               default:    queue_word(MODE_LOAD, $urandom(), rand_coord(), rand_coord(),
                                      rand_coord(), $urandom());
            endcase
         end
         k += n + 4;
      end
   endtask

   initial begin
      tbl_count = 0;
      foreach (tbl_used[j]) tbl_used[j] = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_LOAD;
      req_bus.node_id = '0;
      req_bus.coord_x = '0;
      req_bus.coord_y = '0;
      req_bus.coord_z = '0;
      req_bus.slot_index = '0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, extremes, each mode
      queue_word(MODE_READ, 20'h0, 32'h0, 32'h0, 32'h0, 8'h00);
      queue_word(MODE_MATCH, 20'hFFFFF, 32'h0, 32'h0, 32'h0, 8'hFF);
      queue_word(MODE_LOAD, 20'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'hFF);
      queue_word(MODE_LOAD, 20'hFFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'h00);
      queue_word(MODE_LOAD, 20'h12345, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 8'h55);
      queue_word(MODE_LOAD, 20'h54321, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 8'hAA);
      queue_word(MODE_READ, 20'h0, 32'h0, 32'h0, 32'h0, 8'd1);
      queue_word(MODE_READ, 20'h0, 32'h0, 32'h0, 32'h0, 8'd4);
      queue_word(MODE_READ, 20'h0, 32'h0, 32'h0, 32'h0, 8'hFF);
      queue_near_match(2, 0);
      queue_near_match(2, 0);
      queue_word(MODE_READ, 20'h0, 32'h0, 32'h0, 32'h0, 8'd2);
      queue_word(MODE_READ, 20'h0, 32'h0, 32'h0, 32'h0, 8'd3);
      queue_near_match(0, 0);
      queue_word(MODE_MATCH, 20'hABCDE, 32'h0, 32'h0, 32'h0, 8'h0);
      queue_near_match(1, 0);
      queue_word(MODE_MATCH, 20'h00001, 32'h0, 32'h0, 32'h0, 8'h0);
      queue_word(MODE_CLEAR, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      queue_word(MODE_READ, 20'h0, 32'h0, 32'h0, 32'h0, 8'd0);
      queue_word(MODE_MATCH, 20'h0, 32'h0, 32'h0, 32'h0, 8'h0);
      random_round(200);
      wait_idle();

      // quarter turn in the yz plane, widest tolerance; table filled past its end
      write_reg(CSR_ROT_COS, 48'h0);
      write_reg(CSR_ROT_SIN, 48'h4000_0000);
      write_reg(CSR_AXIS, {46'b0, AXIS_X});
      write_reg(CSR_ABS_TOL, 48'hFFFF_FFFF);
      write_reg(CSR_REL_TOL, 48'hFFFF_FFFF_FFFF);
      queue_word(MODE_CLEAR, 20'h0, 32'h0, 32'h0, 32'h0, 8'h0);
      for (int i = 0; i < DEPTH + 2; i++)
         queue_word(MODE_LOAD, $urandom(), rand_coord(), rand_coord(), rand_coord(),
                    $urandom());
      queue_word(MODE_READ, 20'h0, 32'h0, 32'h0, 32'h0, 8'hFF);
      for (int i = 0; i < 6; i++) queue_near_match($urandom_range(0, DEPTH - 1), 5);
      queue_word(MODE_READ, 20'h0, 32'h0, 32'h0, 32'h0, 8'hFF);
      random_round(80);
      wait_idle();

      // half turn in the xz plane, zero tolerance
      send_idle_pct = 66;
      recv_idle_pct = 12;
      write_reg(CSR_ROT_COS, 48'hFFFF_C000_0000);
      write_reg(CSR_ROT_SIN, 48'h0);
      write_reg(CSR_AXIS, {46'b0, AXIS_Y});
      write_reg(CSR_ABS_TOL, 48'h0);
      write_reg(CSR_REL_TOL, 48'h0);
      random_round(200);
      wait_idle();

      // eighth turn, axis code three acts as z
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_ROT_COS, 48'd759250125);
      write_reg(CSR_ROT_SIN, -48'd759250125);
      write_reg(CSR_AXIS, 48'd3);
      write_reg(CSR_ABS_TOL, {16'b0, 32'($urandom_range(0, 4096))});
      write_reg(CSR_REL_TOL, 48'h0100_0000_0000);
      random_round(200);
      wait_idle();

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // sender: next word when the current one was taken or none is up
   always @(posedge clock) begin
      req_taken <= req_bus.valid && req_bus.ready;
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_bus.valid || req_taken) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               node_word_type w;
               w = pending_words.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.mode       <= w.mode;
               req_bus.node_id    <= w.node_id;
               req_bus.coord_x    <= w.x;
               req_bus.coord_y    <= w.y;
               req_bus.coord_z    <= w.z;
               req_bus.slot_index <= w.slot;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("result word with nothing expected");
            mismatches++;
         end else begin
            match_result_type e;
            e = expected_results.pop_front();
            if (rsp_bus.status !== e.status) begin
               $error("status expected %0d got %0d", e.status, rsp_bus.status);
               mismatches++;
            end
            if (rsp_bus.left_id !== e.left_id) begin
               $error("left_id expected %0h got %0h", e.left_id, rsp_bus.left_id);
               mismatches++;
            end
            if (rsp_bus.right_id !== e.right_id) begin
               $error("right_id expected %0h got %0h", e.right_id, rsp_bus.right_id);
               mismatches++;
            end
            if (rsp_bus.slot_found !== e.slot_found) begin
               $error("slot_found expected %0d got %0d", e.slot_found, rsp_bus.slot_found);
               mismatches++;
            end
            if (rsp_bus.slot_used !== e.slot_used) begin
               $error("slot_used expected %0d got %0d", e.slot_used, rsp_bus.slot_used);
               mismatches++;
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== files.f =====
design/rnm_pkg.sv
design/rnm_req_if.sv
design/rnm_rsp_if.sv
design/rotated_nearest_node_matcher.sv
sim/testbench.sv
